### hdl/ssmd_pkg.sv
package ssmd_pkg;

    localparam int WORD_W      = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_WORD_A = 2'd0,
        ACT_WORD_B = 2'd1,
        ACT_END_A  = 2'd2,
        ACT_END_B  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REQ_A      = 2'd0,
        REQ_B      = 2'd1,
        REQ_EITHER = 2'd2,
        REQ_NONE   = 2'd3
    } t_request;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_HELD  = 2'd1,
        ERR_ENDED = 2'd2
    } t_error;

    // classified beat as it travels from front to back
    typedef struct packed {
        logic              to_b;
        logic              is_end;
        logic [WORD_W-1:0] word;
    } t_item;

endpackage

### hdl/ssmd_front.sv
module ssmd_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_item_valid,
    output logic                       o_item_stall,
    input  logic [1:0]                 i_action,
    input  logic [ssmd_pkg::WORD_W-1:0] i_word,
    input  logic                       i_q_full,
    output logic                       o_push,
    output ssmd_pkg::t_item            o_item
);

    logic            r_valid;
    logic            n_valid;
    ssmd_pkg::t_item r_item;
    ssmd_pkg::t_item n_item;
    logic            accept;

    assign o_item_stall = r_valid && i_q_full;
    assign accept       = i_item_valid && !o_item_stall;
    assign o_push       = r_valid && !i_q_full;
    assign o_item       = r_item;

    always_comb begin
        n_item      = r_item;
        n_item.word = i_word;
        unique case (ssmd_pkg::t_action'(i_action))
            ssmd_pkg::ACT_WORD_A: begin
                n_item.to_b   = 1'b0;
                n_item.is_end = 1'b0;
            end
            ssmd_pkg::ACT_WORD_B: begin
                n_item.to_b   = 1'b1;
                n_item.is_end = 1'b0;
            end
            ssmd_pkg::ACT_END_A: begin
                n_item.to_b   = 1'b0;
                n_item.is_end = 1'b1;
            end
            default: begin
                n_item.to_b   = 1'b1;
                n_item.is_end = 1'b1;
            end
        endcase
    end

    always_comb begin
        priority if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

### hdl/ssmd_queue.sv
module ssmd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ssmd_pkg::t_item i_item,
    input  logic            i_pop,
    output ssmd_pkg::t_item o_item,
    output logic            o_full,
    output logic            o_empty
);

    ssmd_pkg::t_item                  r_slot [ssmd_pkg::QUEUE_DEPTH];
    logic [ssmd_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [ssmd_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [ssmd_pkg::QCNT_W-1:0]      r_count;
    logic [ssmd_pkg::QPTR_W-1:0]      n_wr_ptr;
    logic [ssmd_pkg::QPTR_W-1:0]      n_rd_ptr;
    logic [ssmd_pkg::QCNT_W-1:0]      n_count;

    localparam logic [ssmd_pkg::QPTR_W-1:0] LastPtr =
        ssmd_pkg::QPTR_W'(ssmd_pkg::QUEUE_DEPTH - 1);
    localparam logic [ssmd_pkg::QCNT_W-1:0] FullCnt =
        ssmd_pkg::QCNT_W'(ssmd_pkg::QUEUE_DEPTH);

    assign o_full  = (r_count == FullCnt);
    assign o_empty = (r_count == '0);
    assign o_item  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

### hdl/ssmd_back.sv
module ssmd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ssmd_pkg::t_item             i_item,
    input  logic                        i_q_empty,
    output logic                        o_pop,
    output logic                        o_res_valid,
    input  logic                        i_res_stall,
    output logic [ssmd_pkg::WORD_W-1:0] o_out_word,
    output logic                        o_out_valid,
    output logic [1:0]                  o_request,
    output logic                        o_done_res,
    output logic [1:0]                  o_error
);

    // merge state
    logic [ssmd_pkg::WORD_W-1:0] r_head_a;
    logic [ssmd_pkg::WORD_W-1:0] r_head_b;
    logic [ssmd_pkg::WORD_W-1:0] r_last;
    logic                        r_head_a_held;
    logic                        r_head_b_held;
    logic                        r_ended_a;
    logic                        r_ended_b;
    logic                        r_last_valid;
    logic [ssmd_pkg::WORD_W-1:0] n_head_a;
    logic [ssmd_pkg::WORD_W-1:0] n_head_b;
    logic [ssmd_pkg::WORD_W-1:0] n_last;
    logic                        n_head_a_held;
    logic                        n_head_b_held;
    logic                        n_ended_a;
    logic                        n_ended_b;
    logic                        n_last_valid;

    // result register
    logic                        r_res_valid;
    logic [ssmd_pkg::WORD_W-1:0] r_out_word;
    logic                        r_out_valid;
    ssmd_pkg::t_request          r_request;
    logic                        r_done_res;
    ssmd_pkg::t_error            r_error;
    logic [ssmd_pkg::WORD_W-1:0] n_out_word;
    logic                        n_out_valid;
    ssmd_pkg::t_request          n_request;
    logic                        n_done_res;
    ssmd_pkg::t_error            n_error;

    logic                        held;
    logic                        ended;
    logic                        can_emit;
    logic                        pick_a;
    logic [ssmd_pkg::WORD_W-1:0] pick_word;

    assign o_pop       = !i_q_empty && (!r_res_valid || !i_res_stall);
    assign o_res_valid = r_res_valid;
    assign o_out_word  = r_out_word;
    assign o_out_valid = r_out_valid;
    assign o_request   = r_request;
    assign o_done_res  = r_done_res;
    assign o_error     = r_error;

    always_comb begin
        n_head_a      = r_head_a;
        n_head_b      = r_head_b;
        n_last        = r_last;
        n_head_a_held = r_head_a_held;
        n_head_b_held = r_head_b_held;
        n_ended_a     = r_ended_a;
        n_ended_b     = r_ended_b;
        n_last_valid  = r_last_valid;
        n_out_word    = '0;
        n_out_valid   = 1'b0;
        n_done_res    = 1'b0;
        n_error       = ssmd_pkg::ERR_OK;
        n_request     = ssmd_pkg::REQ_EITHER;
        can_emit      = 1'b0;
        pick_a        = 1'b0;

        held  = i_item.to_b ? r_head_b_held : r_head_a_held;
        ended = i_item.to_b ? r_ended_b : r_ended_a;

        // take the beat into the heads or end flags
        priority if (ended) begin
            n_error = ssmd_pkg::ERR_ENDED;
        end else if (held) begin
            n_error = ssmd_pkg::ERR_HELD;
        end else if (i_item.is_end) begin
            if (i_item.to_b) begin
                n_ended_b = 1'b1;
            end else begin
                n_ended_a = 1'b1;
            end
        end else if (i_item.to_b) begin
            n_head_b      = i_item.word;
            n_head_b_held = 1'b1;
        end else begin
            n_head_a      = i_item.word;
            n_head_a_held = 1'b1;
        end

        priority if (n_head_a_held && n_head_b_held) begin
            can_emit = 1'b1;
            pick_a   = (n_head_a <= n_head_b);
        end else if (n_head_a_held && n_ended_b) begin
            can_emit = 1'b1;
            pick_a   = 1'b1;
        end else if (n_head_b_held && n_ended_a) begin
            can_emit = 1'b1;
            pick_a   = 1'b0;
        end else begin
            can_emit = 1'b0;
        end

        pick_word = pick_a ? n_head_a : n_head_b;

        if (can_emit) begin
            if (pick_a) begin
                n_head_a_held = 1'b0;
                n_head_a      = '0;
            end else begin
                n_head_b_held = 1'b0;
                n_head_b      = '0;
            end
            // drop repeats of the last word sent
            if (!r_last_valid || (pick_word != r_last)) begin
                n_out_word   = pick_word;
                n_out_valid  = 1'b1;
                n_last       = pick_word;
                n_last_valid = 1'b1;
            end
        end

        priority if (n_ended_a && n_ended_b) begin
            n_done_res    = 1'b1;
            n_request     = ssmd_pkg::REQ_NONE;
            n_head_a      = '0;
            n_head_b      = '0;
            n_last        = '0;
            n_head_a_held = 1'b0;
            n_head_b_held = 1'b0;
            n_ended_a     = 1'b0;
            n_ended_b     = 1'b0;
            n_last_valid  = 1'b0;
        end else if (n_head_a_held) begin
            n_request = ssmd_pkg::REQ_B;
        end else if (n_head_b_held) begin
            n_request = ssmd_pkg::REQ_A;
        end else if (n_ended_a) begin
            n_request = ssmd_pkg::REQ_B;
        end else if (n_ended_b) begin
            n_request = ssmd_pkg::REQ_A;
        end else begin
            n_request = ssmd_pkg::REQ_EITHER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_a_held <= 1'b0;
            r_head_b_held <= 1'b0;
            r_ended_a     <= 1'b0;
            r_ended_b     <= 1'b0;
            r_last_valid  <= 1'b0;
            r_res_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_head_a_held <= n_head_a_held;
                r_head_b_held <= n_head_b_held;
                r_ended_a     <= n_ended_a;
                r_ended_b     <= n_ended_b;
                r_last_valid  <= n_last_valid;
                r_res_valid   <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_head_a   <= n_head_a;
            r_head_b   <= n_head_b;
            r_last     <= n_last;
            r_out_word <= n_out_word;
            r_out_valid <= n_out_valid;
            r_request  <= n_request;
            r_done_res <= n_done_res;
            r_error    <= n_error;
        end
    end

endmodule

### hdl/sorted_stream_merge_dedup_core.sv
// two-way merge of ascending 64-bit word streams with duplicate removal
//
// input channel (i_item_valid / o_item_stall): one beat carries i_action
// (word of a, word of b, end of a, end of b) and i_word. output channel
// (o_res_valid / i_res_stall): exactly one result beat for each input beat,
// in order, carrying the emitted word and its flag, the stream to feed next,
// the done flag and the error code.
//
// an accepted beat is registered in the input stage, then passes a
// two-entry queue into the merge unit, which updates the heads and writes
// the result register. throughput is one beat per cycle while the result
// side is not stalled, set by the combinational 64-bit compare and select
// in the merge unit.
//
// a stalled result holds in the output register while the queue and input
// stage keep taking beats; o_item_stall rises only when both are full.
// synchronous reset empties the pipeline and clears the held and end flags;
// after the second end marker the unit returns to that same empty state.
module sorted_stream_merge_dedup_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_item_valid,
    output logic                        o_item_stall,
    input  logic [1:0]                  i_action,
    input  logic [ssmd_pkg::WORD_W-1:0] i_word,
    output logic                        o_res_valid,
    input  logic                        i_res_stall,
    output logic [ssmd_pkg::WORD_W-1:0] o_out_word,
    output logic                        o_out_valid,
    output logic [1:0]                  o_request,
    output logic                        o_done_res,
    output logic [1:0]                  o_error
);

    ssmd_pkg::t_item front_item;
    ssmd_pkg::t_item q_item;
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;

    ssmd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item_valid),
        .o_item_stall (o_item_stall),
        .i_action     (i_action),
        .i_word       (i_word),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_item       (front_item)
    );

    ssmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ssmd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (q_item),
        .i_q_empty   (q_empty),
        .o_pop       (q_pop),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_out_word  (o_out_word),
        .o_out_valid (o_out_valid),
        .o_request   (o_request),
        .o_done_res  (o_done_res),
        .o_error     (o_error)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> o_res_valid)
        else $error("merge step left no result");

    a_done_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_done_res) |->
            (o_request == ssmd_pkg::REQ_NONE) && !o_out_valid)
        else $error("done result carries a word or a request");

    a_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_out_valid) |-> (o_out_word == '0))
        else $error("word present without its flag");

endmodule

### test/tb_sorted_stream_merge_dedup_core.sv
`timescale 1ns / 100ps

module tb_sorted_stream_merge_dedup_core;

    localparam int WORD_W      = ssmd_pkg::WORD_W;
    localparam int N_ITEMS     = 550;
    localparam int QUIET_AFTER = 470;
    localparam int STUCK_LIMIT = 2000;
    localparam int LONG_HOLD   = 60;

    typedef struct {
        logic [WORD_W-1:0]  word;
        logic               valid;
        ssmd_pkg::t_request req;
        logic               done;
        ssmd_pkg::t_error   err;
    } t_merge_result;

    class merge_tracker;
        logic [WORD_W-1:0]  head_a, head_b, last_word;
        bit                 a_held, b_held, a_ended, b_ended, last_ok;
        ssmd_pkg::t_request next_req = ssmd_pkg::REQ_EITHER;
        bit                 last_done;
        int                 failures;
        int                 n_checked;
        t_merge_result      due_results[$];

        function void clear_state();
            head_a = '0;
            head_b = '0;
            last_word = '0;
            a_held = 0;
            b_held = 0;
            a_ended = 0;
            b_ended = 0;
            last_ok = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // predict the result beat caused by one accepted input beat
        function void accept_item(ssmd_pkg::t_action act, logic [WORD_W-1:0] w);
            t_merge_result     r;
            bit                to_b, is_end, pick_a, can_emit;
            logic [WORD_W-1:0] v;
            to_b = act[0];
            is_end = act[1];
            r = '{word: '0, valid: 1'b0, req: ssmd_pkg::REQ_EITHER, done: 1'b0,
                  err: ssmd_pkg::ERR_OK};
            if (to_b ? b_ended : a_ended) begin
                r.err = ssmd_pkg::ERR_ENDED;
            end else if (to_b ? b_held : a_held) begin
                r.err = ssmd_pkg::ERR_HELD;
            end else if (is_end) begin
                if (to_b) b_ended = 1; else a_ended = 1;
            end else if (to_b) begin
                head_b = w;
                b_held = 1;
            end else begin
                head_a = w;
                a_held = 1;
            end

            can_emit = 1;
            pick_a = 0;
            if (a_held && b_held) pick_a = (head_a <= head_b);
            else if (a_held && b_ended) pick_a = 1;
            else if (b_held && a_ended) pick_a = 0;
            else can_emit = 0;

            if (can_emit) begin
                v = pick_a ? head_a : head_b;
                if (pick_a) a_held = 0; else b_held = 0;
                // repeated value is consumed silently
                if (!last_ok || v != last_word) begin
                    r.word = v;
                    r.valid = 1'b1;
                    last_word = v;
                    last_ok = 1;
                end
            end

            if (a_ended && b_ended) begin
                r.done = 1'b1;
                r.req = ssmd_pkg::REQ_NONE;
                clear_state();
            end else if (a_held) r.req = ssmd_pkg::REQ_B;
            else if (b_held) r.req = ssmd_pkg::REQ_A;
            else if (a_ended) r.req = ssmd_pkg::REQ_B;
            else if (b_ended) r.req = ssmd_pkg::REQ_A;
            else r.req = ssmd_pkg::REQ_EITHER;

            next_req = r.req;
            last_done = r.done;
            due_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [WORD_W-1:0] exp_v,
                                    logic [WORD_W-1:0] got_v);
            if (got_v !== exp_v) begin
                failures++;
                $display("%0t: %s mismatch: expected %h, actual %h",
                         $time, name, exp_v, got_v);
            end
        endfunction

        function void check_result(logic [WORD_W-1:0] word, logic valid, logic [1:0] req,
                                   logic done, logic [1:0] err);
            t_merge_result r;
            n_checked++;
            if (due_results.size() == 0) begin
                failures++;
                $display("%0t: unexpected result beat: expected none, actual word %h valid %b",
                         $time, word, valid);
                return;
            end
            r = due_results.pop_front();
            compare_field("out_word", r.word, word);
            compare_field("out_valid", WORD_W'(r.valid), WORD_W'(valid));
            compare_field("request", WORD_W'(r.req), WORD_W'(req));
            compare_field("done_res", WORD_W'(r.done), WORD_W'(done));
            compare_field("error", WORD_W'(r.err), WORD_W'(err));
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_item_valid = 1'b0;
    logic              o_item_stall;
    logic [1:0]        i_action = ssmd_pkg::ACT_WORD_A;
    logic [WORD_W-1:0] i_word = '0;
    logic              o_res_valid;
    logic              i_res_stall = 1'b0;
    logic [WORD_W-1:0] o_out_word;
    logic              o_out_valid;
    logic [1:0]        o_request;
    logic              o_done_res;
    logic [1:0]        o_error;

    merge_tracker sb = new();
    int           n_sent;
    int           n_session;
    bit           quiet;

    sorted_stream_merge_dedup_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item_valid),
        .o_item_stall (o_item_stall),
        .i_action     (i_action),
        .i_word       (i_word),
        .o_res_valid  (o_res_valid),
        .i_res_stall  (i_res_stall),
        .o_out_word   (o_out_word),
        .o_out_valid  (o_out_valid),
        .o_request    (o_request),
        .o_done_res   (o_done_res),
        .o_error      (o_error)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_item(ssmd_pkg::t_action act, logic [WORD_W-1:0] w);
        int gap;
        // every fourth session the sender runs without gaps
        if (!quiet && (n_session % 4) != 3 && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge i_clk);
            i_item_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_item_valid <= 1'b1;
        i_action <= act;
        i_word <= w;
        do @(posedge i_clk); while (o_item_stall);
        sb.accept_item(act, w);
        n_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_item_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // ascending run with frequent repeats, saturating at the top
    function automatic void make_run(ref logic [WORD_W-1:0] q[$], input int n,
                                     input logic [WORD_W-1:0] start);
        logic [WORD_W:0] v;
        v = {1'b0, start};
        for (int k = 0; k < n; k++) begin
            q.push_back(v[WORD_W-1:0]);
            if ($urandom_range(0, 7) == 0) v = v + $urandom();
            else v = v + $urandom_range(0, 3);
            if (v[WORD_W]) v = {1'b0, {WORD_W{1'b1}}};
        end
    endfunction

    task automatic run_merge_session();
        logic [WORD_W-1:0] a_words[$];
        logic [WORD_W-1:0] b_words[$];
        logic [WORD_W-1:0] start, w;
        ssmd_pkg::t_action act;
        bit                use_b;
        case ($urandom_range(0, 2))
            0: start = rand_word();
            1: start = WORD_W'($urandom_range(0, 20));
            default: start = {WORD_W{1'b1}} - WORD_W'($urandom_range(0, 20));
        endcase
        make_run(a_words, $urandom_range(0, 8), start);
        make_run(b_words, $urandom_range(0, 8), start);
        do begin
            if ($urandom_range(0, 19) == 0) begin
                act = ssmd_pkg::t_action'($urandom_range(0, 3));
                w = rand_word();
            end else begin
                use_b = (sb.next_req != ssmd_pkg::REQ_A) &&
                        (sb.next_req == ssmd_pkg::REQ_B || $urandom_range(0, 1) == 1);
                w = rand_word();
                if (use_b) begin
                    act = (b_words.size() != 0) ? ssmd_pkg::ACT_WORD_B : ssmd_pkg::ACT_END_B;
                    if (b_words.size() != 0) w = b_words.pop_front();
                end else begin
                    act = (a_words.size() != 0) ? ssmd_pkg::ACT_WORD_A : ssmd_pkg::ACT_END_A;
                    if (a_words.size() != 0) w = a_words.pop_front();
                end
            end
            if (n_sent >= QUIET_AFTER) quiet = 1;
            send_item(act, w);
        end while (!sb.last_done);
        n_session++;
    endtask

    // result side: random stall bursts plus one long hold-off
    initial begin
        int  hold_left;
        bit  long_done;
        hold_left = 0;
        long_done = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0) begin
                if (!long_done && sb.n_checked >= 100) begin
                    long_done = 1;
                    hold_left = LONG_HOLD;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    hold_left = $urandom_range(1, 9);
                end
            end
            if (hold_left > 0) begin
                i_res_stall <= 1'b1;
                hold_left--;
            end else begin
                i_res_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && !i_res_stall)
            sb.check_result(o_out_word, o_out_valid, o_request, o_done_res, o_error);
    end

    // ends the run when neither channel moves for too long
    initial begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_item_valid && !o_item_stall) || (o_res_valid && !i_res_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        sb.clear_state();

        // first word, held stream, end while held, ties and repeats
        send_item(ssmd_pkg::ACT_WORD_A, '0);
        send_item(ssmd_pkg::ACT_WORD_A, 64'd5);
        send_item(ssmd_pkg::ACT_END_A, rand_word());
        send_item(ssmd_pkg::ACT_WORD_B, '0);
        send_item(ssmd_pkg::ACT_WORD_A, '0);
        send_item(ssmd_pkg::ACT_WORD_A, {WORD_W{1'b1}});
        send_item(ssmd_pkg::ACT_WORD_B, {WORD_W{1'b1}});
        send_item(ssmd_pkg::ACT_END_A, '0);
        // items for an ended stream
        send_item(ssmd_pkg::ACT_WORD_A, 64'd123);
        send_item(ssmd_pkg::ACT_END_A, '0);
        send_item(ssmd_pkg::ACT_WORD_B, 64'h8000_0000_0000_0000);
        send_item(ssmd_pkg::ACT_END_B, '0);
        // completion with one stream empty
        send_item(ssmd_pkg::ACT_END_B, '0);
        send_item(ssmd_pkg::ACT_END_B, '0);
        send_item(ssmd_pkg::ACT_WORD_A, 64'h5555_5555_5555_5555);
        send_item(ssmd_pkg::ACT_WORD_A, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(ssmd_pkg::ACT_END_A, {WORD_W{1'b1}});
        // b first, then a cross-stream repeat
        send_item(ssmd_pkg::ACT_WORD_B, 64'd7);
        send_item(ssmd_pkg::ACT_WORD_A, 64'd9);
        send_item(ssmd_pkg::ACT_WORD_B, 64'd9);
        send_item(ssmd_pkg::ACT_WORD_A, 64'd9);
        send_item(ssmd_pkg::ACT_END_A, '0);
        send_item(ssmd_pkg::ACT_END_B, '0);

        drain();
        while (n_sent < N_ITEMS) begin
            run_merge_session();
            if (n_session == 15) drain();
        end

        quiet = 1;
        drain();
        repeat (10) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
